/* hdl/mlbs_pkg.sv */
package mlbs_pkg;

    localparam int IN_WIDTH  = 32;
    localparam int OUT_WIDTH = 48;

    typedef struct packed {
        logic cell_end;
        logic row_end;
        logic first_row;
    } t_flags;

endpackage

/* hdl/mlbs_sat_add.sv */
module mlbs_sat_add #(
    parameter int W = 48
) (
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_sum
);

    logic signed [W:0] s_wide;

    assign s_wide = {i_a[W-1], i_a} + {i_b[W-1], i_b};

    always_comb begin
        if (s_wide[W] != s_wide[W-1]) begin
            o_sum = s_wide[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            o_sum = s_wide[W-1:0];
        end
    end

endmodule

/* hdl/mlbs_col_store.sv */
module mlbs_col_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // same-cycle write to the address being fetched is forwarded
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/max_left_box_sum_stream_top.sv */
// Channel | Direction | Handshake               | Word
// in      | sink      | i_in_valid / o_in_stall | element_value, end_of_cell, end_of_row, first_row
// out     | source    | o_out_valid / i_out_stall | max_left_sum, column_overflow
//
// One word per cycle unless a held result stalls a row end; results are registered after stage 1.
// Stage 0 sums the cell; stage 1 does the column read-modify-write, the row prefix and max.
// The column total for the next cell is fetched ahead from the column store at the next index.
// i_rst_n is synchronous; the column store is not cleared and holds garbage until written.
// A held result stalls stage 1 only when that stage also closes a row.
module max_left_box_sum_stream_top #(
    parameter int MAX_COLUMNS = 1024,
    parameter int ACC_WIDTH   = 48
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [mlbs_pkg::IN_WIDTH-1:0]   i_element_value,
    input  logic                                   i_end_of_cell,
    input  logic                                   i_end_of_row,
    input  logic                                   i_first_row,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [mlbs_pkg::OUT_WIDTH-1:0]  o_max_left_sum,
    output logic                                   o_column_overflow
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int OW = mlbs_pkg::OUT_WIDTH;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [CW-1:0] COL_LIMIT = CW'(MAX_COLUMNS);

    // stage 0
    logic signed [ACC_WIDTH-1:0] r_cell_sum;
    logic signed [ACC_WIDTH-1:0] s_elem;
    logic signed [ACC_WIDTH-1:0] s_cell_next;
    logic                        s_in_acc;
    logic                        s_in_close;

    // stage 1
    logic                        r_s1_valid;
    mlbs_pkg::t_flags            r_s1;
    logic signed [ACC_WIDTH-1:0] r_s1_cell;
    logic signed [ACC_WIDTH-1:0] r_prefix;
    logic signed [ACC_WIDTH-1:0] r_best;
    logic [CW-1:0]               r_col_idx;
    logic                        r_ovf;
    logic [CW-1:0]               n_col_idx;
    logic                        s_go;
    logic                        s_close;
    logic                        s_in_range;
    logic signed [ACC_WIDTH-1:0] s_rd_total;
    logic signed [ACC_WIDTH-1:0] s_col_sum;
    logic signed [ACC_WIDTH-1:0] s_total;
    logic signed [ACC_WIDTH-1:0] s_prefix;
    logic signed [ACC_WIDTH-1:0] s_best;
    logic                        s_wr_en;
    logic [AW-1:0]               s_rd_addr;

    // output
    logic                        r_out_valid;
    logic signed [OW-1:0]        r_out_sum;
    logic                        r_out_ovf;
    logic                        s_out_free;

    assign s_out_free = !r_out_valid || !i_out_stall;
    assign s_go       = r_s1_valid && (s_out_free || !r_s1.row_end);
    assign o_in_stall = r_s1_valid && !s_go;
    assign s_in_acc   = i_in_valid && !o_in_stall;

    assign s_elem     = ACC_WIDTH'(i_element_value);
    assign s_in_close = i_end_of_cell || i_end_of_row;

    mlbs_sat_add #(.W(ACC_WIDTH)) u_cell_add (
        .i_a   (r_cell_sum),
        .i_b   (s_elem),
        .o_sum (s_cell_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_sum <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s_in_acc) begin
                r_cell_sum <= s_in_close ? '0 : s_cell_next;
                r_s1_valid <= 1'b1;
            end else if (s_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_s1_cell      <= s_cell_next;
            r_s1.cell_end  <= i_end_of_cell;
            r_s1.row_end   <= i_end_of_row;
            r_s1.first_row <= i_first_row;
        end
    end

    assign s_close    = r_s1.cell_end || r_s1.row_end;
    assign s_in_range = r_col_idx < COL_LIMIT;
    assign s_wr_en    = s_go && s_close && s_in_range;

    mlbs_sat_add #(.W(ACC_WIDTH)) u_col_add (
        .i_a   (s_rd_total),
        .i_b   (r_s1_cell),
        .o_sum (s_col_sum)
    );

    always_comb begin
        if (!s_in_range || r_s1.first_row) begin
            s_total = r_s1_cell;
        end else begin
            s_total = s_col_sum;
        end
    end

    mlbs_sat_add #(.W(ACC_WIDTH)) u_prefix_add (
        .i_a   (r_prefix),
        .i_b   (s_total),
        .o_sum (s_prefix)
    );

    assign s_best = (s_prefix > r_best) ? s_prefix : r_best;

    always_comb begin
        n_col_idx = r_col_idx;
        if (s_go) begin
            if (r_s1.row_end) begin
                n_col_idx = '0;
            end else if (s_close && s_in_range) begin
                n_col_idx = r_col_idx + 1'b1;
            end
        end
    end

    assign s_rd_addr = (n_col_idx < COL_LIMIT) ? n_col_idx[AW-1:0] : '0;

    mlbs_col_store #(
        .DEPTH (MAX_COLUMNS),
        .AW    (AW),
        .DW    (ACC_WIDTH)
    ) u_col_store (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (r_col_idx[AW-1:0]),
        .i_wr_data (s_total),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix    <= '0;
            r_best      <= ACC_MIN;
            r_col_idx   <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_col_idx <= n_col_idx;
            if (s_go && r_s1.row_end) begin
                r_prefix    <= '0;
                r_best      <= ACC_MIN;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (s_go && s_close) begin
                    r_prefix <= s_prefix;
                    r_best   <= s_best;
                    r_ovf    <= r_ovf || !s_in_range;
                end
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // row end always closes a cell
    always_ff @(posedge i_clk) begin
        if (s_go && r_s1.row_end) begin
            r_out_sum <= OW'(s_best);
            r_out_ovf <= r_ovf || !s_in_range;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_max_left_sum    = r_out_sum;
    assign o_column_overflow = r_out_ovf;

    a_col_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_idx <= COL_LIMIT)
        else $error("column index past store depth");

    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_col_idx == COL_LIMIT))
        else $error("overflow flag without full column count");

    a_out_from_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid && i_out_stall)) |-> $past(s_go && r_s1.row_end))
        else $error("result without a row end");

    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && r_s1.row_end) |=> (r_prefix == '0 && r_col_idx == '0 && !r_ovf))
        else $error("row state not cleared after row end");

endmodule
